@@ rtl/afr_pkg.sv @@
// Shared types and codes for the ACL fragment reassembly block.
package afr_pkg;

    localparam logic [11:0] HANDLE_MASK = 12'hFFF;
    localparam logic [15:0] MAX_FRAME_RESET = 16'd2048;
    localparam logic [15:0] INDEX_MAX = 16'hFFFF;
    localparam logic [16:0] L2CAP_HDR_BYTES = 17'd4;

    localparam logic [1:0] PB_CONT  = 2'h1;
    localparam logic [1:0] PB_FIRST = 2'h2;

    localparam logic [1:0] ST_FRAME    = 2'h0;
    localparam logic [1:0] ST_EXCESS   = 2'h1;
    localparam logic [1:0] ST_MISMATCH = 2'h2;
    localparam logic [1:0] ST_LIMIT    = 2'h3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        fragment_start;
        logic [11:0] conn_handle;
        logic [1:0]  pb_flag;
        logic [15:0] fragment_length;
    } afr_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] frame_offset;
        logic        frame_end;
        logic [1:0]  status;
        logic [11:0] frame_handle;
    } afr_out_t;

endpackage

@@ rtl/acl_fragment_reassembly.sv @@
// Top level of the HCI ACL to L2CAP frame reassembly block.
//
// Input channel s_*: one ACL payload byte per transaction; the header fields
// (handle, packet boundary flag, fragment length) are read on the byte that
// carries fragment_start. Result channel m_*: zero or one result per input
// byte, with the byte, its frame offset, a frame_end mark, a status code and
// the frame's handle. Rejected fragments report once, on their first byte or on the byte that reaches the limit.
// cfg_wr_en/cfg_wr_data write max_frame_bytes (2048 after reset); write it
// only while no transaction is in flight.
// A result is registered in the output register (or in the skid stage while the
// receiver stalls) before it appears on m_valid. Throughput: one byte per cycle
// while s_ready is high; the core state and the output register update per byte.
// Reset (aresetn low, synchronous) clears the frame state and empties the
// output buffer. When the receiver stalls, one further result parks in the
// skid stage; s_ready drops only while that stage is full.
module acl_fragment_reassembly (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  afr_pkg::afr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output afr_pkg::afr_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);

    logic [15:0]       max_frame_reg;
    logic              accept;
    logic              res_valid;
    afr_pkg::afr_out_t res_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_reg <= afr_pkg::MAX_FRAME_RESET;
        end else if (cfg_wr_en) begin
            max_frame_reg <= cfg_wr_data;
        end
    end

    assign accept = s_valid && s_ready;

    afr_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .in_item         (s_data),
        .max_frame_bytes (max_frame_reg),
        .res_valid       (res_valid),
        .res_item        (res_item)
    );

    afr_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_item  (res_item),
        .can_accept (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ rtl/afr_core.sv @@
// Reassembly state and per-byte decision logic.
module afr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  afr_pkg::afr_in_t  in_item,
    input  logic [15:0]       max_frame_bytes,
    output logic              res_valid,
    output afr_pkg::afr_out_t res_item
);

    logic [11:0] handle_reg, handle_next;
    logic [15:0] index_reg, index_next;
    logic [16:0] exp_len_reg, exp_len_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic        len_known_reg, len_known_next;
    logic        open_reg, open_next;
    logic        drop_reg, drop_next;

    always_comb begin
        logic        done;
        logic [15:0] off;
        logic        fend;
        logic [1:0]  st;
        logic        emit;

        handle_next    = handle_reg;
        index_next     = index_reg;
        exp_len_next   = exp_len_reg;
        len_low_next   = len_low_reg;
        len_known_next = len_known_reg;
        open_next      = open_reg;
        drop_next      = drop_reg;
        done = 1'b0;
        emit = 1'b0;
        off  = index_reg;
        fend = 1'b0;
        st   = afr_pkg::ST_FRAME;

        if (in_item.fragment_start) begin
            drop_next = 1'b0;
            if (in_item.pb_flag == afr_pkg::PB_FIRST) begin
                handle_next    = in_item.conn_handle & afr_pkg::HANDLE_MASK;
                index_next     = '0;
                exp_len_next   = '0;
                len_low_next   = '0;
                len_known_next = 1'b0;
                open_next      = 1'b1;
            end else if (in_item.pb_flag == afr_pkg::PB_CONT
                         && in_item.conn_handle != handle_reg) begin
                drop_next = 1'b1;
                emit = 1'b1;
                st   = afr_pkg::ST_MISMATCH;
                done = 1'b1;
            end
            // reject a fragment that cannot fit in the frame limit
            if (!done && open_next
                && ({1'b0, index_next} + {1'b0, in_item.fragment_length})
                   > {1'b0, max_frame_bytes}) begin
                drop_next = 1'b1;
                open_next = 1'b0;
                emit = 1'b1;
                off  = index_next;
                st   = afr_pkg::ST_LIMIT;
                done = 1'b1;
            end
        end

        if (!done && !drop_next) begin
            off  = index_next;
            emit = 1'b1;
            if (!open_next) begin
                st = afr_pkg::ST_EXCESS;
                if (index_next != afr_pkg::INDEX_MAX) index_next = index_next + 16'd1;
            end else if (index_next >= max_frame_bytes) begin
                drop_next = 1'b1;
                open_next = 1'b0;
                st = afr_pkg::ST_LIMIT;
            end else begin
                if (off == 16'd0) begin
                    len_low_next = in_item.data_byte;
                end else if (off == 16'd1) begin
                    exp_len_next = {1'b0, in_item.data_byte, len_low_next}
                                   + afr_pkg::L2CAP_HDR_BYTES;
                    len_known_next = 1'b1;
                end
                if (index_next != afr_pkg::INDEX_MAX) index_next = index_next + 16'd1;
                // close the frame on the byte that reaches the expected length
                if (len_known_next && ({1'b0, off} + 17'd1) == exp_len_next) begin
                    fend = 1'b1;
                    open_next = 1'b0;
                end
            end
        end

        res_valid             = accept && emit;
        res_item.out_byte     = in_item.data_byte;
        res_item.frame_offset = off;
        res_item.frame_end    = fend;
        res_item.status       = st;
        res_item.frame_handle = handle_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            handle_reg    <= '0;
            index_reg     <= '0;
            exp_len_reg   <= '0;
            len_low_reg   <= '0;
            len_known_reg <= 1'b0;
            open_reg      <= 1'b0;
            drop_reg      <= 1'b0;
        end else if (accept) begin
            handle_reg    <= handle_next;
            index_reg     <= index_next;
            exp_len_reg   <= exp_len_next;
            len_low_reg   <= len_low_next;
            len_known_reg <= len_known_next;
            open_reg      <= open_next;
            drop_reg      <= drop_next;
        end
    end

    a_end_is_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_item.frame_end) |-> res_item.status == afr_pkg::ST_FRAME)
        else $error("frame_end on a non-frame result");
    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_item.frame_end) |=> !open_reg)
        else $error("frame still open after frame_end");
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && drop_reg && !in_item.fragment_start) |-> !res_valid)
        else $error("result from a dropped fragment");

endmodule

@@ rtl/afr_out_buf.sv @@
// Output register with a skid stage for the result channel.
module afr_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  afr_pkg::afr_out_t push_item,
    output logic              can_accept,
    output logic              m_valid,
    input  logic              m_ready,
    output afr_pkg::afr_out_t m_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    afr_pkg::afr_out_t out_reg, out_next;
    afr_pkg::afr_out_t skid_reg, skid_next;

    assign can_accept = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                // advance the parked transaction
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = push_item;
                out_valid_next = push;
            end
        end else if (push) begin
            // hold the new result while the receiver stalls
            skid_next       = push_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output register empty");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !out_valid_reg) |=> (out_valid_reg && out_reg == $past(push_item)))
        else $error("result lost on an empty buffer");

endmodule

@@ tb/sv/acl_fragment_reassembly_test.sv @@
// Self-checking testbench for the ACL fragment reassembly block.
module acl_fragment_reassembly_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Packet boundary codes that append without a handle check.
    localparam logic [1:0] PB_APPEND     = 2'h0;
    localparam logic [1:0] PB_APPEND_ALT = 2'h3;
    localparam int RANDOM_BYTES_PER_PHASE = 375;
    localparam int SETTLE_LIMIT = 4000;

    class frame_tracker;
        logic [15:0]       max_frame;
        logic [11:0]       frame_handle;
        logic [15:0]       byte_idx;
        logic [16:0]       frame_len;
        logic [7:0]        len_low;
        bit                len_known;
        bit                frame_is_open;
        bit                dropping;
        afr_pkg::afr_out_t pending_results[$];
        int                errors;

        function new();
            max_frame = afr_pkg::MAX_FRAME_RESET;
            frame_handle = '0;
            byte_idx = '0;
            frame_len = '0;
            len_low = '0;
            len_known = 0;
            frame_is_open = 0;
            dropping = 0;
            errors = 0;
        endfunction

        function void set_max_frame(logic [15:0] value);
            max_frame = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_result(logic [7:0] data, logic [15:0] offset, logic last,
                                  logic [1:0] code);
            afr_pkg::afr_out_t res;
            res.out_byte = data;
            res.frame_offset = offset;
            res.frame_end = last;
            res.status = code;
            res.frame_handle = frame_handle;
            pending_results.push_back(res);
        endfunction

        function void advance_index();
            if (byte_idx != afr_pkg::INDEX_MAX) begin
                byte_idx++;
            end
        endfunction

        // Work out the result, if any, of one accepted input byte.
        function void note_byte(afr_pkg::afr_in_t item);
            logic [15:0] offset;
            logic        last;
            last = 1'b0;
            if (item.fragment_start) begin
                dropping = 0;
                if (item.pb_flag == afr_pkg::PB_FIRST) begin
                    frame_handle = item.conn_handle;
                    byte_idx = '0;
                    frame_len = '0;
                    len_low = '0;
                    len_known = 0;
                    frame_is_open = 1;
                end else if (item.pb_flag == afr_pkg::PB_CONT
                             && item.conn_handle != frame_handle) begin
                    dropping = 1;
                    push_result(item.data_byte, byte_idx, 1'b0, afr_pkg::ST_MISMATCH);
                    return;
                end
                if (frame_is_open &&
                    ({1'b0, byte_idx} + {1'b0, item.fragment_length} > {1'b0, max_frame})) begin
                    dropping = 1;
                    frame_is_open = 0;
                    push_result(item.data_byte, byte_idx, 1'b0, afr_pkg::ST_LIMIT);
                    return;
                end
            end
            if (dropping) begin
                return;
            end
            if (!frame_is_open) begin
                offset = byte_idx;
                advance_index();
                push_result(item.data_byte, offset, 1'b0, afr_pkg::ST_EXCESS);
                return;
            end
            if (byte_idx >= max_frame) begin
                dropping = 1;
                frame_is_open = 0;
                push_result(item.data_byte, byte_idx, 1'b0, afr_pkg::ST_LIMIT);
                return;
            end
            offset = byte_idx;
            if (offset == 16'd0) begin
                len_low = item.data_byte;
            end else if (offset == 16'd1) begin
                frame_len = {1'b0, item.data_byte, len_low} + afr_pkg::L2CAP_HDR_BYTES;
                len_known = 1;
            end
            advance_index();
            if (len_known && ({1'b0, offset} + 17'd1 == frame_len)) begin
                last = 1'b1;
                frame_is_open = 0;
            end
            push_result(item.data_byte, offset, last, afr_pkg::ST_FRAME);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, name, want, seen);
            end
        endfunction

        function void check_result(afr_pkg::afr_out_t got);
            afr_pkg::afr_out_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got 0x%0h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare_field("frame_offset", want.frame_offset, got.frame_offset);
            compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("frame_handle", 16'(want.frame_handle), 16'(got.frame_handle));
        endfunction

        function void drop_missing();
            while (pending_results.size() != 0) begin
                errors++;
                $display("%0t: missing result: expected 0x%0h, got none",
                         $time, pending_results[0]);
                void'(pending_results.pop_front());
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    afr_pkg::afr_in_t  s_data;
    logic              m_valid;
    logic              m_ready = 1'b0;
    afr_pkg::afr_out_t m_data;
    logic              cfg_wr_en;
    logic [15:0]       cfg_wr_data;

    frame_tracker tracker = new();
    logic [7:0]   frag_bytes[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           bytes_sent = 0;
    logic [11:0]  last_handle = '0;

    acl_fragment_reassembly dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_data);
        end
    end

    // Hold valid and payload until the transaction is taken.
    task automatic send_byte(input afr_pkg::afr_in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        tracker.note_byte(item);
        bytes_sent++;
    endtask

    // Header fields on non-start bytes are ignored, so fill them with noise.
    task automatic send_fragment(input logic [11:0] handle, input logic [1:0] pb,
                                 input logic [15:0] declared);
        afr_pkg::afr_in_t item;
        foreach (frag_bytes[i]) begin
            item.data_byte = frag_bytes[i];
            item.fragment_start = (i == 0);
            item.conn_handle = (i == 0) ? handle : 12'($urandom);
            item.pb_flag = (i == 0) ? pb : 2'($urandom);
            item.fragment_length = (i == 0) ? declared : 16'($urandom_range(1, 65535));
            send_byte(item);
        end
    endtask

    // Drop valid, wait out every pending result, then let the pipeline go quiet.
    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (tracker.pending() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        tracker.drop_missing();
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_frame(input logic [15:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_max_frame(value);
    endtask

    task automatic run_random_frame();
        int          payload_len;
        int          total;
        int          pos;
        int          frag_size;
        int          choice;
        logic [11:0] handle;
        logic [11:0] frag_handle;
        logic [1:0]  pb;
        logic [15:0] declared;
        logic [7:0]  frame_data[$];
        case ($urandom_range(0, 4))
            0: handle = '0;
            1: handle = afr_pkg::HANDLE_MASK;
            2: handle = last_handle;
            default: handle = 12'($urandom);
        endcase
        last_handle = handle;
        payload_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                   : $urandom_range(0, 40);
        total = payload_len + 4;
        // Occasionally pad the frame with excess bytes or cut it short.
        choice = $urandom_range(0, 19);
        if (choice == 0) begin
            total += $urandom_range(1, 6);
        end else if (choice == 1) begin
            total = $urandom_range(1, total);
        end
        for (int i = 0; i < total; i++) begin
            if (i == 0) begin
                frame_data.push_back(8'(payload_len));
            end else if (i == 1) begin
                frame_data.push_back(8'(payload_len >> 8));
            end else begin
                frame_data.push_back(8'($urandom));
            end
        end
        pos = 0;
        while (pos < total) begin
            frag_size = $urandom_range(1, 16);
            if (frag_size > total - pos) begin
                frag_size = total - pos;
            end
            frag_handle = handle;
            choice = $urandom_range(0, 99);
            if (pos == 0 || choice >= 94) begin
                pb = afr_pkg::PB_FIRST;
            end else if (choice < 78) begin
                pb = afr_pkg::PB_CONT;
            end else if (choice < 86) begin
                pb = $urandom_range(0, 1) ? PB_APPEND_ALT : PB_APPEND;
                frag_handle = 12'($urandom);
            end else begin
                pb = afr_pkg::PB_CONT;
                frag_handle = handle ^ 12'($urandom_range(1, 4095));
            end
            choice = $urandom_range(0, 19);
            if (choice == 0) begin
                declared = 16'($urandom_range(1, 65535));
            end else if (choice == 1) begin
                declared = 16'($urandom_range(1, 24));
            end else begin
                declared = 16'(frag_size);
            end
            frag_bytes = {};
            for (int i = 0; i < frag_size; i++) begin
                frag_bytes.push_back(frame_data[pos + i]);
            end
            send_fragment(frag_handle, pb, declared);
            pos += frag_size;
        end
        // Stray fragment with arbitrary header.
        if ($urandom_range(0, 9) == 0) begin
            frag_bytes = {};
            for (int i = 0; i < $urandom_range(1, 4); i++) begin
                frag_bytes.push_back(8'($urandom));
            end
            send_fragment(12'($urandom), 2'($urandom), 16'($urandom_range(1, 65535)));
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [15:0] limit);
        int first_byte;
        write_max_frame(limit);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES_PER_PHASE) begin
            run_random_frame();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = afr_pkg::MAX_FRAME_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Bytes with no frame open are excess.
        frag_bytes = {8'h00};
        send_fragment(12'h000, PB_APPEND, 16'd1);
        // Continuing fragment on a foreign handle with no frame: flag once, drop rest.
        frag_bytes = {8'hFF, 8'h11};
        send_fragment(afr_pkg::HANDLE_MASK, afr_pkg::PB_CONT, 16'hFFFF);
        // Open a 9-byte frame, interrupt with a mismatch, append, then finish.
        frag_bytes = {8'h05, 8'h00, 8'h80};
        send_fragment(12'hABC, afr_pkg::PB_FIRST, 16'd3);
        frag_bytes = {8'h01, 8'h02};
        send_fragment(12'h543, afr_pkg::PB_CONT, 16'd2);
        frag_bytes = {8'h7F, 8'h01};
        send_fragment(12'h000, PB_APPEND_ALT, 16'd2);
        frag_bytes = {8'h20, 8'h40, 8'h08, 8'h10};
        send_fragment(12'hABC, afr_pkg::PB_CONT, 16'd4);
        // Closed frame: further bytes are excess.
        frag_bytes = {8'hAA};
        send_fragment(12'h000, PB_APPEND, 16'd1);
        frag_bytes = {8'h55};
        send_fragment(12'hABC, afr_pkg::PB_CONT, 16'd1);
        // Declared length over the limit at fragment start.
        frag_bytes = {8'h04, 8'h00};
        send_fragment(12'h3C3, afr_pkg::PB_FIRST, 16'd2049);

        write_max_frame(16'd4);
        // Smallest frame, exactly at the limit.
        frag_bytes = {8'h00, 8'h00, 8'h11, 8'h22};
        send_fragment(12'h001, afr_pkg::PB_FIRST, 16'd4);
        // Fragment longer than declared runs into the limit mid fragment.
        frag_bytes = {8'h01, 8'h00, 8'h33, 8'h44, 8'h66, 8'h77};
        send_fragment(12'h802, afr_pkg::PB_FIRST, 16'd4);

        run_random_phase(0, 0, 16'($urandom_range(8, 80)));
        run_random_phase(60, 0, afr_pkg::MAX_FRAME_RESET);
        run_random_phase(0, 60, afr_pkg::INDEX_MAX);
        run_random_phase(20, 20, 16'($urandom_range(4, 40)));

        settle();
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ acl_fragment_reassembly.f @@
rtl/afr_pkg.sv
rtl/afr_core.sv
rtl/afr_out_buf.sv
rtl/acl_fragment_reassembly.sv
tb/sv/acl_fragment_reassembly_test.sv
